FILE: sv/btgl_pkg.sv
// Shared types and constants for the bitmap text glyph layout block.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none
package btgl_pkg;

  localparam int POS_W   = 24;
  localparam int CELL_W  = 25;   // glyph size times 8.8 scale
  localparam int DIV_W   = 25;   // dividend and divisor width of the divider
  localparam int ADD_W   = 34;   // wide enough for any pen update before saturation
  localparam int RECT_W  = 15;

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LOW_A   = 8'h61;
  localparam logic [7:0] CH_LOW_Z   = 8'h7A;
  localparam logic [7:0] CASE_DIFF  = 8'h20;

  typedef enum logic [2:0] {
    REG_GLYPH_WIDTH  = 3'd0,
    REG_GLYPH_HEIGHT = 3'd1,
    REG_SHEET_COLS   = 3'd2,
    REG_SHEET_ROWS   = 3'd3,
    REG_FIRST_CODE   = 3'd4,
    REG_FORCE_UPPER  = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    CLS_NONE,
    CLS_SPACE,
    CLS_NEWLINE,
    CLS_TAB,
    CLS_GLYPH
  } cls_t;

  typedef struct packed {
    cls_t                    cls;
    logic                    start;
    logic signed [POS_W-1:0] origin_x;
    logic signed [POS_W-1:0] origin_y;
    logic [15:0]             scale;
    logic [7:0]              alpha;
    logic [23:0]             rgb;
    logic signed [8:0]       glyph_id;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_EXEC,
    ST_DIV,
    ST_MUL,
    ST_TADD,
    ST_OUT
  } eng_state_t;

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [ADD_W-1:0] v);
    logic signed [ADD_W-1:0] lo;
    logic signed [ADD_W-1:0] hi;
    lo = -(ADD_W'(1) <<< (POS_W - 1));
    hi = (ADD_W'(1) <<< (POS_W - 1)) - ADD_W'(1);
    if (v < lo) return lo[POS_W-1:0];
    if (v > hi) return hi[POS_W-1:0];
    return v[POS_W-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: sv/btgl_front.sv
// Front end: takes characters, classifies them and holds them in a two-entry queue.
// Depends on btgl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module btgl_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  output logic                 full,
  input  wire logic [7:0]      char_code,
  input  wire logic            string_start,
  input  wire logic [23:0]     origin_x,
  input  wire logic [23:0]     origin_y,
  input  wire logic [15:0]     scale_factor,
  input  wire logic [7:0]      alpha_in,
  input  wire logic [23:0]     rgb_in,
  input  wire logic            force_upper,
  input  wire logic [6:0]      first_glyph_code,
  output logic                 item_valid,
  input  wire logic            item_take,
  output btgl_pkg::item_t      item
);
  import btgl_pkg::*;

  item_t       store [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  item_t       cls_item;
  logic [7:0]  ch;
  logic        do_push;
  logic        do_pop;

  always_comb begin
    ch = char_code;
    if (force_upper && char_code >= CH_LOW_A && char_code <= CH_LOW_Z) begin
      ch = char_code - CASE_DIFF;
    end
    cls_item.start    = string_start;
    cls_item.origin_x = origin_x;
    cls_item.origin_y = origin_y;
    cls_item.scale    = scale_factor;
    cls_item.alpha    = alpha_in;
    cls_item.rgb      = rgb_in;
    // The character is a signed byte; the id may go negative.
    cls_item.glyph_id = 9'({ch[7], ch}) - 9'({2'b00, first_glyph_code});
    priority if (char_code == 8'd0 || scale_factor == 16'd0 || alpha_in == 8'd0) begin
      cls_item.cls = CLS_NONE;
    end else if (char_code == CH_SPACE) begin
      cls_item.cls = CLS_SPACE;
    end else if (char_code == CH_NEWLINE) begin
      cls_item.cls = CLS_NEWLINE;
    end else if (char_code == CH_TAB) begin
      cls_item.cls = CLS_TAB;
    end else begin
      cls_item.cls = CLS_GLYPH;
    end
  end

  assign full       = (count == 2'd2);
  assign item_valid = (count != 2'd0);
  assign item       = store[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = item_take && item_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= cls_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule
`default_nettype wire

FILE: sv/btgl_div.sv
// Restoring divider, one quotient bit per cycle, that also tracks the quotient
// modulo the tab stop. Depends on btgl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module btgl_div #(
  parameter int TAB_STOP = 4
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic [btgl_pkg::DIV_W-1:0]        dividend,
  input  wire logic [btgl_pkg::DIV_W-1:0]        divisor,
  output logic                                   busy,
  output logic [btgl_pkg::DIV_W-1:0]             quot,
  output logic [btgl_pkg::DIV_W-1:0]             rem,
  output logic [$clog2(TAB_STOP+1)-1:0]          qmod
);
  import btgl_pkg::*;

  localparam int MW    = $clog2(TAB_STOP + 1);
  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] dvd;
  logic [DIV_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W:0]   trial;
  logic             qbit;
  logic [MW:0]      mod_trial;

  always_comb begin
    trial     = {rem, dvd[DIV_W-1]};
    qbit      = (trial >= {1'b0, dvs});
    mod_trial = {qmod, qbit};
    if (mod_trial >= (MW+1)'(TAB_STOP)) begin
      mod_trial = mod_trial - (MW+1)'(TAB_STOP);
    end
  end

  assign quot = dvd;

  always_ff @(posedge clk) begin
    if (start) begin
      dvd  <= dividend;
      dvs  <= divisor;
      rem  <= '0;
      qmod <= '0;
    end else if (busy) begin
      // Quotient bits shift in where dividend bits shift out.
      dvd  <= {dvd[DIV_W-2:0], qbit};
      rem  <= qbit ? DIV_W'(trial - {1'b0, dvs}) : trial[DIV_W-1:0];
      qmod <= mod_trial[MW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(DIV_W);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) busy <= 1'b0;
    end
  end

endmodule
`default_nettype wire

FILE: sv/btgl_engine.sv
// Back end: keeps the pen, carries out one classified character at a time and
// holds the draw command in an output register. Depends on btgl_pkg and btgl_div.
`timescale 1ns / 1ps
`default_nettype none
module btgl_engine #(
  parameter int TAB_STOP = 4
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                item_valid,
  output logic                     item_take,
  input  wire btgl_pkg::item_t     item,
  input  wire logic [8:0]          glyph_width,
  input  wire logic [8:0]          glyph_height,
  input  wire logic [6:0]          sheet_columns,
  input  wire logic [6:0]          sheet_rows,
  output logic                     empty,
  input  wire logic                pop,
  output logic [23:0]              dest_x,
  output logic [23:0]              dest_y,
  output logic [14:0]              src_left,
  output logic [14:0]              src_top,
  output logic [14:0]              src_right,
  output logic [14:0]              src_bottom,
  output logic [15:0]              scale_out,
  output logic [7:0]               alpha_out,
  output logic [23:0]              rgb_out,
  output logic                     glyph_unmapped
);
  import btgl_pkg::*;

  localparam int MW = $clog2(TAB_STOP + 1);
  localparam int SW = $clog2(2 * TAB_STOP);

  eng_state_t              state;
  eng_state_t              state_next;
  item_t                   cur;
  logic signed [POS_W-1:0] pen_x;
  logic signed [POS_W-1:0] pen_y;
  logic signed [POS_W-1:0] line_start_x;
  logic [CELL_W-1:0]       cell_w;
  logic [CELL_W-1:0]       cell_h;
  logic                    unmapped;
  logic [15:0]             left_full;
  logic [15:0]             top_full;
  logic [SW+CELL_W-1:0]    tab_prod;
  logic                    out_valid;

  logic                    div_start;
  logic                    div_busy;
  logic [DIV_W-1:0]        div_dividend;
  logic [DIV_W-1:0]        div_divisor;
  logic [DIV_W-1:0]        div_quot;
  logic [DIV_W-1:0]        div_rem;
  logic [MW-1:0]           div_qmod;

  logic signed [POS_W:0]   diff;
  logic [SW-1:0]           tab_steps;
  logic                    out_free;
  logic [13:0]             cells;

  btgl_div #(.TAB_STOP(TAB_STOP)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quot     (div_quot),
    .rem      (div_rem),
    .qmod     (div_qmod)
  );

  assign diff     = (POS_W+1)'(pen_x) - (POS_W+1)'(line_start_x);
  assign out_free = !out_valid || pop;
  assign cells    = sheet_columns * sheet_rows;

  always_comb begin
    // A negative cell count keeps the sign of its remainder.
    if (diff[POS_W]) begin
      tab_steps = SW'(TAB_STOP) + SW'(div_qmod);
    end else begin
      tab_steps = SW'(TAB_STOP) - SW'(div_qmod);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (item_valid) state_next = ST_SCALE;
      ST_SCALE: state_next = (cur.cls == CLS_NONE) ? ST_IDLE : ST_EXEC;
      ST_EXEC: begin
        unique case (cur.cls)
          CLS_TAB:   state_next = (cell_w == '0) ? ST_IDLE : ST_DIV;
          CLS_GLYPH: state_next = unmapped ? ST_OUT : ST_DIV;
          default:   state_next = ST_IDLE;
        endcase
      end
      ST_DIV:   if (!div_busy) state_next = ST_MUL;
      ST_MUL:   state_next = (cur.cls == CLS_TAB) ? ST_TADD : ST_OUT;
      ST_TADD:  state_next = ST_IDLE;
      ST_OUT:   if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    item_take    = (state == ST_IDLE) && item_valid;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    if (state == ST_EXEC) begin
      if (cur.cls == CLS_TAB) begin
        div_start    = (cell_w != '0);
        div_dividend = diff[POS_W] ? DIV_W'(-diff) : DIV_W'(diff);
        div_divisor  = cell_w;
      end else if (cur.cls == CLS_GLYPH) begin
        div_start    = !unmapped;
        div_dividend = DIV_W'(cur.glyph_id[7:0]);
        div_divisor  = DIV_W'(sheet_columns);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pen_x        <= '0;
      pen_y        <= '0;
      line_start_x <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (item_valid && item.start) begin
            pen_x        <= item.origin_x;
            pen_y        <= item.origin_y;
            line_start_x <= item.origin_x;
          end
        end
        ST_EXEC: begin
          if (cur.cls == CLS_SPACE) begin
            pen_x <= sat_pos(ADD_W'(pen_x) + ADD_W'(cell_w));
          end else if (cur.cls == CLS_NEWLINE) begin
            pen_y <= sat_pos(ADD_W'(pen_y) + ADD_W'(cell_h));
            pen_x <= line_start_x;
          end
        end
        ST_TADD: pen_x <= sat_pos(ADD_W'(pen_x) + ADD_W'(tab_prod));
        ST_OUT: begin
          // The pen moves by the cell width truncated to whole pixels.
          if (out_free) begin
            pen_x <= sat_pos(ADD_W'(pen_x) + ADD_W'({cell_w[CELL_W-1:8], 8'h00}));
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      cur <= item;
    end
    if (state == ST_SCALE) begin
      cell_w   <= glyph_width * cur.scale;
      cell_h   <= glyph_height * cur.scale;
      unmapped <= cur.glyph_id[8] || ({5'd0, cur.glyph_id} >= cells);
      left_full <= '0;
      top_full  <= '0;
    end
    if (state == ST_MUL) begin
      tab_prod  <= tab_steps * cell_w;
      left_full <= div_rem[6:0] * glyph_width;
      top_full  <= div_quot[6:0] * glyph_height;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      dest_x         <= pen_x;
      dest_y         <= pen_y;
      src_left       <= left_full[RECT_W-1:0];
      src_top        <= top_full[RECT_W-1:0];
      src_right      <= RECT_W'(left_full + 16'(glyph_width));
      src_bottom     <= RECT_W'(top_full + 16'(glyph_height));
      scale_out      <= cur.scale;
      alpha_out      <= cur.alpha;
      rgb_out        <= cur.rgb;
      glyph_unmapped <= unmapped;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  assign empty = !out_valid;

endmodule
`default_nettype wire

FILE: sv/bitmap_text_glyph_layout.sv
// Top level of the bitmap text glyph layout block: configuration registers,
// front queue and back engine. Depends on btgl_pkg, btgl_front, btgl_engine.
//
// Characters enter through push/full, one per transfer, together with the
// start flag, origin, scale and color. Draw commands leave through empty/pop:
// the oldest command sits on the result ports while empty is low.
// A two-entry queue takes characters while the engine works on an earlier one.
// Per character the engine goes through IDLE and SCALE for invisible characters
// and the terminator, also EXEC for spaces and newlines, also OUT for a glyph
// outside the sheet; a mapped glyph or tab waits in DIV on the serial divider,
// one quotient bit per cycle over 25 bits, then passes MUL and OUT or TADD.
// A command that is not popped stalls the engine after it finishes the next
// glyph; the queue then fills and full rises.
// Configuration writes (cfg_we, cfg_addr, cfg_wdata) take effect at once; the
// user must make them only while the block is idle, which it does not enforce.
// Reset clears the pen, line start, queue and output, and loads sheet defaults.
`timescale 1ns / 1ps
`default_nettype none
module bitmap_text_glyph_layout #(
  parameter int TAB_STOP = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [8:0]  cfg_wdata,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  char_code,
  input  wire logic        string_start,
  input  wire logic [23:0] origin_x,
  input  wire logic [23:0] origin_y,
  input  wire logic [15:0] scale_factor,
  input  wire logic [7:0]  alpha_in,
  input  wire logic [23:0] rgb_in,
  output logic             empty,
  input  wire logic        pop,
  output logic [23:0]      dest_x,
  output logic [23:0]      dest_y,
  output logic [14:0]      src_left,
  output logic [14:0]      src_top,
  output logic [14:0]      src_right,
  output logic [14:0]      src_bottom,
  output logic [15:0]      scale_out,
  output logic [7:0]       alpha_out,
  output logic [23:0]      rgb_out,
  output logic             glyph_unmapped
);
  import btgl_pkg::*;

  logic [8:0] glyph_width;
  logic [8:0] glyph_height;
  logic [6:0] sheet_columns;
  logic [6:0] sheet_rows;
  logic [6:0] first_glyph_code;
  logic       force_upper;
  logic       item_valid;
  logic       item_take;
  item_t      item;

  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_width      <= 9'd32;
      glyph_height     <= 9'd32;
      sheet_columns    <= 7'd10;
      sheet_rows       <= 7'd6;
      first_glyph_code <= 7'd32;
      force_upper      <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_GLYPH_WIDTH:  glyph_width      <= cfg_wdata;
        REG_GLYPH_HEIGHT: glyph_height     <= cfg_wdata;
        REG_SHEET_COLS:   sheet_columns    <= cfg_wdata[6:0];
        REG_SHEET_ROWS:   sheet_rows       <= cfg_wdata[6:0];
        REG_FIRST_CODE:   first_glyph_code <= cfg_wdata[6:0];
        REG_FORCE_UPPER:  force_upper      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  btgl_front u_front (
    .clk              (clk),
    .rst              (rst),
    .push             (push),
    .full             (full),
    .char_code        (char_code),
    .string_start     (string_start),
    .origin_x         (origin_x),
    .origin_y         (origin_y),
    .scale_factor     (scale_factor),
    .alpha_in         (alpha_in),
    .rgb_in           (rgb_in),
    .force_upper      (force_upper),
    .first_glyph_code (first_glyph_code),
    .item_valid       (item_valid),
    .item_take        (item_take),
    .item             (item)
  );

  btgl_engine #(.TAB_STOP(TAB_STOP)) u_engine (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_take      (item_take),
    .item           (item),
    .glyph_width    (glyph_width),
    .glyph_height   (glyph_height),
    .sheet_columns  (sheet_columns),
    .sheet_rows     (sheet_rows),
    .empty          (empty),
    .pop            (pop),
    .dest_x         (dest_x),
    .dest_y         (dest_y),
    .src_left       (src_left),
    .src_top        (src_top),
    .src_right      (src_right),
    .src_bottom     (src_bottom),
    .scale_out      (scale_out),
    .alpha_out      (alpha_out),
    .rgb_out        (rgb_out),
    .glyph_unmapped (glyph_unmapped)
  );

endmodule
`default_nettype wire
